### rtl/lfsq_pkg.sv
// ----------------------------------------------------------------------------
// lfsq_pkg: shared types and constants for the largest free square finder
// Holds the grid limits, the field widths and the register indexes.
// ----------------------------------------------------------------------------
package lfsq_pkg;

    // Largest grid the line buffer can hold.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Column and row indexes address one cell; sizes can reach the maximum.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 11;
    localparam int SCORE_W = 11;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    // Configuration register indexes.
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Position and flags of a cell on its way through the score stage.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cell_free;
        logic             first_row;
        logic             last_col;
        logic             last_cell;
    } cell_info_t;

endpackage

### rtl/largest_free_square_finder_top.sv
// ----------------------------------------------------------------------------
// largest_free_square_finder_top: maximal free square over a raster grid
// One cell per item in, one result item per grid out.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, cell_free) carries one grid cell per
// item in raster order, 1 for a free cell and 0 for an obstacle. After the
// last cell of a grid of grid_height rows by grid_width columns, the output
// channel (out_valid, out_stall) delivers one item: square_size and the
// top_row, left_col corner of the largest all-free square. Ties go to the
// square whose bottom-right corner comes first in raster order. A grid with
// no free cell reports size 0 at corner 0,0. The next grid starts at once.
// Throughput is one cell per cycle unless stalled, set by the single line
// buffer memory, which is read for a cell in its accept cycle and written
// back as the score stage retires it. The output register lets the block
// take cells while a result waits; only a second finished grid behind a
// stalled result holds the input off. Reset clears the position and running
// best square and sets both grid registers to 1024. The line buffer holds
// no reset value and needs no clearing pass. Configuration writes (cfg_we,
// cfg_index, cfg_data) must be made by the user while idle; not enforced.
// ----------------------------------------------------------------------------
module largest_free_square_finder_top
    import lfsq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [DIM_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cell_free,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [SCORE_W-1:0] square_size,
    output logic [ROW_W-1:0]   top_row,
    output logic [COL_W-1:0]   left_col
);

    // Configuration registers.
    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;

    // Position of the next cell to arrive.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             last_col;
    logic             last_row;
    logic             in_fire;

    // Score stage.
    logic               s1_valid_reg;
    cell_info_t         s1_info_reg;
    cell_info_t         s1_info_next;
    logic               s1_hold;
    logic               s1_fire;
    logic               fwd_reg;
    logic [SCORE_W-1:0] fwd_data_reg;
    logic [SCORE_W-1:0] up_score;
    logic [SCORE_W-1:0] min_score;
    logic [SCORE_W-1:0] score;

    // Neighbor scores and running best.
    logic [SCORE_W-1:0] left_reg;
    logic [SCORE_W-1:0] diag_reg;
    logic [SCORE_W-1:0] best_size_reg;
    logic [ROW_W-1:0]   best_row_reg;
    logic [COL_W-1:0]   best_col_reg;
    logic [SCORE_W-1:0] best_size_next;
    logic [ROW_W-1:0]   best_row_next;
    logic [COL_W-1:0]   best_col_next;

    // Line buffer holding the scores of the row above.
    logic [SCORE_W-1:0] line_mem [MAX_WIDTH];
    logic [SCORE_W-1:0] rd_data_reg;

    // Output register.
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_size_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= MAX_W_DIM;
            grid_height_reg <= MAX_H_DIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero size acts as one, an oversized value as the maximum.
    always_comb
    begin
        if (grid_width_reg == '0)
            width_eff = DIM_W'(1);
        else if (grid_width_reg > MAX_W_DIM)
            width_eff = MAX_W_DIM;
        else
            width_eff = grid_width_reg;

        if (grid_height_reg == '0)
            height_eff = DIM_W'(1);
        else if (grid_height_reg > MAX_H_DIM)
            height_eff = MAX_H_DIM;
        else
            height_eff = grid_height_reg;
    end

    // ------------------------------------------------------------------
    // Input side: position counters and line buffer read
    // ------------------------------------------------------------------
    // The score stage holds only when it carries a finished grid and the
    // output register is still full and stalled.
    assign s1_hold  = s1_info_reg.last_cell && out_valid_reg && out_stall;
    assign s1_fire  = s1_valid_reg && !s1_hold;
    assign in_stall = s1_valid_reg && s1_hold;
    assign in_fire  = in_valid && !in_stall;

    assign last_col = (DIM_W'(col_reg) + DIM_W'(1)) >= width_eff;
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= height_eff;

    always_comb
    begin
        s1_info_next.row       = row_reg;
        s1_info_next.col       = col_reg;
        s1_info_next.cell_free = cell_free;
        s1_info_next.first_row = (row_reg == '0);
        s1_info_next.last_col  = last_col;
        s1_info_next.last_cell = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the score stage, plus a bypass for the case where the
    // entry being read is written back in the same cycle (one-column grid).
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_info_reg  <= s1_info_next;
            fwd_reg      <= s1_fire && (s1_info_reg.col == col_reg);
            fwd_data_reg <= score;
        end
    end

    // Line buffer: one read at accept, one write as the score stage retires.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= line_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            line_mem[s1_info_reg.col] <= score;
    end

    // ------------------------------------------------------------------
    // Score stage
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s1_info_reg.first_row)
            up_score = '0;
        else if (fwd_reg)
            up_score = fwd_data_reg;
        else
            up_score = rd_data_reg;

        min_score = (up_score < left_reg) ? up_score : left_reg;
        if (diag_reg < min_score)
            min_score = diag_reg;

        if (!s1_info_reg.cell_free)
            score = '0;
        else if (s1_info_reg.first_row || (s1_info_reg.col == '0))
            score = SCORE_W'(1);
        else
            score = min_score + SCORE_W'(1);

        // A square replaces the best one only when strictly larger.
        if (score > best_size_reg)
        begin
            best_size_next = score;
            best_row_next  = s1_info_reg.row - ROW_W'(score - SCORE_W'(1));
            best_col_next  = s1_info_reg.col - COL_W'(score - SCORE_W'(1));
        end
        else
        begin
            best_size_next = best_size_reg;
            best_row_next  = best_row_reg;
            best_col_next  = best_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else if (s1_fire)
        begin
            left_reg <= s1_info_reg.last_col ? '0 : score;
            diag_reg <= s1_info_reg.last_col ? '0 : up_score;
            if (s1_info_reg.last_cell)
            begin
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end
            else
            begin
                best_size_reg <= best_size_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire && s1_info_reg.last_cell)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_info_reg.last_cell)
        begin
            out_size_reg <= best_size_next;
            out_row_reg  <= best_row_next;
            out_col_reg  <= best_col_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign square_size = out_size_reg;
    assign top_row     = out_row_reg;
    assign left_col    = out_col_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A grid that retires from the score stage shows up at the output.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_info_reg.last_cell) |=> out_valid)
        else $error("finished grid did not reach the output register");

    // An empty result sits at the origin.
    a_empty_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (square_size == '0)) |-> (top_row == '0) && (left_col == '0))
        else $error("empty result reported away from corner 0,0");

    // The reported square lies inside the largest grid.
    a_square_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((DIM_W'(top_row) + square_size) <= MAX_H_DIM) &&
                      ((DIM_W'(left_col) + square_size) <= MAX_W_DIM))
        else $error("reported square extends past the grid limit");

    // The input is held off only while a finished grid waits behind the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && s1_info_reg.last_cell)
        else $error("input stalled without a blocked result");

endmodule

### tb/tb_largest_free_square_finder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_largest_free_square_finder_top: self-checking bench for the square finder
// Streams raster grids of free and obstacle cells into the block, keeps its
// own running model of the square scores, and compares every reported square
// against the expected size and corner. Grid sizes change between grids and,
// in a few directed cases, partway through one.
// ----------------------------------------------------------------------------
module tb_largest_free_square_finder_top
    import lfsq_pkg::*;
();

    // The result leaves through the score stage and the output register and
    // the line buffer write lands as a cell retires, so the idle drain is
    // plenty before a register write or the end of the run.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_CELLS = 700;
    localparam int CALM_CELLS   = 250;
    localparam int HOLD_CYCLES  = 300;

    // One reported square: its side and its top-left corner.
    typedef struct {
        logic [SCORE_W-1:0] side;
        logic [ROW_W-1:0]   top_r;
        logic [COL_W-1:0]   left_c;
    } square_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = REG_GRID_WIDTH;
    logic [DIM_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               cell_free = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [SCORE_W-1:0] square_size;
    logic [ROW_W-1:0]   top_row;
    logic [COL_W-1:0]   left_col;

    // Running copy of the block's state, advanced once per accepted cell.
    logic [DIM_W-1:0]   width_reg  = MAX_W_DIM;
    logic [DIM_W-1:0]   height_reg = MAX_H_DIM;
    logic [SCORE_W-1:0] line_scores [MAX_WIDTH] = '{default: '0};
    logic [SCORE_W-1:0] left_sc   = '0;
    logic [SCORE_W-1:0] diag_sc   = '0;
    logic [SCORE_W-1:0] best_side = '0;
    logic [ROW_W-1:0]   best_top  = '0;
    logic [COL_W-1:0]   best_left = '0;
    logic [ROW_W-1:0]   row_pos   = '0;
    logic [COL_W-1:0]   col_pos   = '0;

    // Squares predicted but not yet seen on the output, oldest first.
    square_t pending_squares[$];

    int  error_count    = 0;
    int  cells_sent     = 0;
    int  grids_done     = 0;
    int  squares_seen   = 0;
    int  input_stalls   = 0;
    int  cycle_count    = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    bit  no_gaps        = 1'b0;

    largest_free_square_finder_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_free   (cell_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .square_size (square_size),
        .top_row     (top_row),
        .left_col    (left_col)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A register value of zero means one; anything past the line buffer
    // size is cut back to that size.
    function automatic int effective_dim(input logic [DIM_W-1:0] value, input int limit);
        if (value == '0)
            return 1;
        return (int'(value) > limit) ? limit : int'(value);
    endfunction

    // Scores one accepted cell and queues the square when it closes a grid.
    task automatic score_cell(input logic free);
        int      w;
        int      h;
        int      col;
        int      row;
        int      up;
        int      score;
        int      least;
        square_t done;
        w   = effective_dim(width_reg, MAX_WIDTH);
        h   = effective_dim(height_reg, MAX_HEIGHT);
        col = (int'(col_pos) < MAX_WIDTH) ? int'(col_pos) : MAX_WIDTH - 1;
        row = int'(row_pos);
        up  = (row > 0) ? int'(line_scores[col]) : 0;
        if (!free)
        begin
            score = 0;
        end
        else if (row == 0 || col == 0)
        begin
            score = 1;
        end
        else
        begin
            least = (up < int'(left_sc)) ? up : int'(left_sc);
            least = (least < int'(diag_sc)) ? least : int'(diag_sc);
            score = least + 1;
        end
        diag_sc          = SCORE_W'(up);
        left_sc          = SCORE_W'(score);
        line_scores[col] = SCORE_W'(score);
        // Only a strictly larger square replaces the best one, so the first
        // bottom-right corner in raster order wins a tie.
        if (score > int'(best_side))
        begin
            best_side = SCORE_W'(score);
            best_top  = ROW_W'(row - (score - 1));
            best_left = COL_W'(col - (score - 1));
        end
        if (col + 1 >= w)
        begin
            col_pos = '0;
            left_sc = '0;
            diag_sc = '0;
            if (row + 1 >= h)
            begin
                done.side   = best_side;
                done.top_r  = best_top;
                done.left_c = best_left;
                pending_squares.push_back(done);
                grids_done++;
                row_pos   = '0;
                best_side = '0;
                best_top  = '0;
                best_left = '0;
            end
            else
            begin
                row_pos = ROW_W'(row + 1);
            end
        end
        else
        begin
            col_pos = COL_W'(col + 1);
        end
    endtask

    // Offers one cell, after a random gap unless the calm stretch is on, and
    // returns at the clock edge that takes it. Valid stays high on return so
    // that back-to-back cells need only one assignment per edge.
    task automatic send_cell(input logic free);
        bit stalled;
        if (!no_gaps)
        begin
            while ($urandom_range(99) < 15)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        cell_free <= free;
        // The stall seen at the falling edge is the one the next rising edge
        // acts on.
        do
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        score_cell(free);
        cells_sent++;
    endtask

    task automatic send_grid(input int w, input int h, input int free_pct);
        for (int n = 0; n < w * h; n++)
            send_cell($urandom_range(99) < free_pct);
    endtask

    // Drops valid, waits for every expected square and lets the pipeline and
    // the line buffer write settle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_squares.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIM_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_GRID_WIDTH)
            width_reg = value;
        else
            height_reg = value;
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        settle();
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
    endtask

    // Mostly small sides so that many grids finish; now and then a wider one.
    function automatic int random_dim();
        return ($urandom_range(99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 20);
    endfunction

    // One-cell grids: an obstacle gives size 0 at the origin, a free cell a
    // square of one.
    task automatic test_single_cell_grids();
        set_grid(1, 1);
        send_cell(1'b0);
        send_cell(1'b1);
    endtask

    // An all-free three by two grid holds two equal squares of side two; the
    // one that closes first, at the origin, must be reported.
    task automatic test_tie_break();
        set_grid(3, 2);
        send_grid(3, 2, 100);
    endtask

    // Zero in both registers behaves as a one-cell grid.
    task automatic test_zero_registers();
        set_grid(0, 0);
        send_cell(1'b1);
        send_cell(1'b0);
    endtask

    // Registers shrunk partway through a grid. The current position already
    // lies past the new last column (row), so the next cell closes the row
    // (grid). Only shrinking is used, so no unwritten line buffer entry is read.
    task automatic test_mid_grid_resize();
        set_grid(4, 2);
        repeat (3) send_cell(1'b1);
        settle();
        write_reg(REG_GRID_WIDTH, 2);
        repeat (3) send_cell(1'b1);

        set_grid(2, 4);
        repeat (5) send_cell(1'b1);
        settle();
        write_reg(REG_GRID_HEIGHT, 2);
        send_cell(1'b1);
    endtask

    // A full-length row. An oversized width acts as the line buffer size and
    // a lone free cell in the last column gives the largest column index.
    task automatic test_size_extremes();
        set_grid(11'h7FF, 0);
        for (int c = 0; c < MAX_WIDTH; c++)
            send_cell(c == MAX_WIDTH - 1);
    endtask

    // Runs of same-sized grids. Most grids are dense so that large squares
    // and ties show up; the rest are sparse noise. The first stretch runs
    // with no idling on either side.
    task automatic test_random_grids();
        int start;
        int w;
        int h;
        start = cells_sent;
        while (cells_sent - start < RANDOM_CELLS)
        begin
            no_gaps = (cells_sent - start) < CALM_CELLS;
            w = random_dim();
            h = random_dim();
            set_grid(DIM_W'(w), DIM_W'(h));
            repeat ($urandom_range(2, 6))
                send_grid(w, h, ($urandom_range(99) < 70) ? $urandom_range(75, 98)
                                                         : $urandom_range(0, 60));
        end
        no_gaps = 1'b0;
    endtask

    // The receiver holds off for a long stretch while tiny grids keep coming,
    // so finished squares pile up and the block must stall its input.
    task automatic test_result_backpressure();
        set_grid(2, 2);
        hold_request = HOLD_CYCLES;
        repeat (16) send_grid(2, 2, 90);
    endtask

    // The sender stops until every expected square has arrived, then carries
    // on with the same grid size.
    task automatic test_sender_pause();
        set_grid(3, 3);
        repeat (3) send_grid(3, 3, 85);
        settle();
        repeat (3) send_grid(3, 3, 85);
    endtask

    // Receiver stall: a requested hold is counted down here; otherwise the
    // stall is random except during the calm stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_left    = hold_request - 1;
            hold_request = 0;
        end
        else
        begin
            out_stall <= !no_gaps && ($urandom_range(99) < 15);
        end
    end

    // Both channels are sampled at the falling edge, where valid and stall
    // hold the values the next rising edge will act on.
    always @(negedge clk)
    begin
        square_t want;
        if (rst_n && in_valid && in_stall)
            input_stalls++;
        if (rst_n && out_valid && !out_stall)
        begin
            squares_seen++;
            if (pending_squares.size() == 0)
            begin
                $error("unexpected result: square_size %0d, top_row %0d, left_col %0d",
                       square_size, top_row, left_col);
                error_count++;
            end
            else
            begin
                want = pending_squares.pop_front();
                if (square_size !== want.side)
                begin
                    $error("square_size mismatch: expected %0d, got %0d",
                           want.side, square_size);
                    error_count++;
                end
                if (top_row !== want.top_r)
                begin
                    $error("top_row mismatch: expected %0d, got %0d", want.top_r, top_row);
                    error_count++;
                end
                if (left_col !== want.left_c)
                begin
                    $error("left_col mismatch: expected %0d, got %0d", want.left_c, left_col);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_cell_grids();
        test_tie_break();
        test_zero_registers();
        test_mid_grid_resize();
        test_size_extremes();
        test_random_grids();
        test_result_backpressure();
        test_sender_pause();
        settle();

        $display("Ran %0d cells through %0d grids and checked %0d squares, from 1x1 up to",
                 cells_sent, grids_done, squares_seen);
        $display("a full-length row, with %0d cycles of input held off by the block.",
                 input_stalls);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
